// ===== hw/rtl/msgs_pkg.sv =====
// Package with shared types, constants and a helper function for the grid smoother.
package msgs_pkg;

    localparam int MAX_WIDTH   = 128;
    localparam int MAX_HEIGHT  = 128;
    localparam int MAX_RADIUS  = 8;
    localparam int COL_W       = $clog2(MAX_WIDTH);
    localparam int ROW_W       = $clog2(MAX_HEIGHT);
    localparam int ADDR_W      = COL_W + ROW_W;
    localparam int DEPTH       = MAX_WIDTH * MAX_HEIGHT;
    localparam int OFS_W       = 5;
    localparam int ACC_W       = 57;
    localparam int WSUM_W      = 26;
    localparam int QUO_W       = 33;

    localparam logic [2:0] REG_WIDTH  = 3'd0;
    localparam logic [2:0] REG_HEIGHT = 3'd1;
    localparam logic [2:0] REG_RADIUS = 3'd2;
    localparam logic [2:0] REG_INNER  = 3'd3;
    localparam logic [2:0] REG_OUTER  = 3'd4;
    localparam logic [2:0] REG_SHARE  = 3'd5;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_READ  = 1'b1;

    typedef struct packed {
        logic start_read;
        logic write_en;
        logic fetch_centre;
        logic step_window;
        logic start_div;
        logic load_out;
    } msgs_cmd_t;

    typedef struct packed {
        logic centre_bad;
        logic copy_mode;
        logic window_done;
        logic share_bad;
        logic div_done;
    } msgs_stat_t;

    function automatic logic [16:0] tap_of(input logic [3:0] k, input logic [63:0] ti,
                                           input logic [63:0] to);
        logic [16:0] t;
        t = '0;
        case (k)
            4'd0: t = 17'h10000;
            4'd1: t = {1'b0, ti[15:0]};
            4'd2: t = {1'b0, ti[31:16]};
            4'd3: t = {1'b0, ti[47:32]};
            4'd4: t = {1'b0, ti[63:48]};
            4'd5: t = {1'b0, to[15:0]};
            4'd6: t = {1'b0, to[31:16]};
            4'd7: t = {1'b0, to[47:32]};
            4'd8: t = {1'b0, to[63:48]};
            default: t = '0;
        endcase
        return t;
    endfunction

endpackage

// ===== hw/rtl/msgs_divider.sv =====
// Restoring divider for the rounded magnitude quotient, one bit per cycle.
module msgs_divider
    import msgs_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [ACC_W-1:0]  dividend,
    input  logic [WSUM_W-1:0] divisor,
    output logic              done,
    output logic [ACC_W-1:0]  quotient
);

    logic [ACC_W-1:0]     quo_reg, quo_next;
    logic [WSUM_W:0]      rem_reg, rem_next;
    logic [WSUM_W-1:0]    den_reg, den_next;
    logic [5:0]           cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [WSUM_W+1:0]    trial;

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg, quo_reg[ACC_W-1]} - {2'b00, den_reg};
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            den_next  = divisor;
            cnt_next  = 6'(ACC_W - 1);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!trial[WSUM_W+1])
            begin
                rem_next = trial[WSUM_W:0];
                quo_next = {quo_reg[ACC_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = {rem_reg[WSUM_W-1:0], quo_reg[ACC_W-1]};
                quo_next = {quo_reg[ACC_W-2:0], 1'b0};
            end
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg - 6'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== hw/rtl/msgs_datapath.sv =====
// Datapath: sample memory, window walk, weight products, sums and result.
module msgs_datapath
    import msgs_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  msgs_cmd_t         cmd,
    output msgs_stat_t        stat,
    input  logic [ROW_W-1:0]  in_row,
    input  logic [COL_W-1:0]  in_col,
    input  logic [31:0]       in_value,
    input  logic              in_missing,
    input  logic [7:0]        grid_width,
    input  logic [7:0]        grid_height,
    input  logic [3:0]        radius,
    input  logic [63:0]       taps_inner,
    input  logic [63:0]       taps_outer,
    input  logic [15:0]       min_valid_share,
    output logic [31:0]       res_value,
    output logic              res_missing
);

    logic [32:0]        mem [DEPTH];
    logic [32:0]        rd_reg;
    logic [ADDR_W-1:0]  rd_addr;

    logic [ROW_W-1:0]   r_reg;
    logic [COL_W-1:0]   c_reg;
    logic [8:0]         w_reg, h_reg;
    logic [3:0]         rad_reg;
    logic [OFS_W-1:0]   i_reg, j_reg;
    logic               p1v_reg;
    logic               p1in_reg;
    logic [16:0]        wt_reg;
    logic [WSUM_W-1:0]  wall_reg, wvalid_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic [31:0]        res_reg;
    logic               miss_reg;
    logic               in_grid_reg;
    logic               last_issue_reg;

    logic signed [OFS_W:0] di, dj;
    logic [3:0]         ai, aj;
    logic [33:0]        prod;
    logic signed [9:0]  rr, cc;
    logic               in_win;
    logic [7:0]         wcfg, hcfg;
    logic               last_issue;
    logic [ACC_W-1:0]   mag, quo;
    logic               div_done;
    logic [47:0]        lhs, rhs;
    logic signed [ACC_W-1:0] wprod;

    assign wcfg = grid_width;
    assign hcfg = grid_height;

    assign di = $signed({1'b0, i_reg}) - $signed({2'b00, rad_reg});
    assign dj = $signed({1'b0, j_reg}) - $signed({2'b00, rad_reg});
    assign ai = di[OFS_W] ? 4'(-di) : 4'(di);
    assign aj = dj[OFS_W] ? 4'(-dj) : 4'(dj);
    assign prod = tap_of(ai, taps_inner, taps_outer) * tap_of(aj, taps_inner, taps_outer);
    assign rr = $signed({3'b000, r_reg}) + 10'(dj);
    assign cc = $signed({3'b000, c_reg}) + 10'(di);
    assign in_win = !rr[9] && (rr < $signed({1'b0, h_reg})) &&
                    !cc[9] && (cc < $signed({1'b0, w_reg}));
    assign last_issue = (i_reg == {rad_reg, 1'b0}) && (j_reg == {rad_reg, 1'b0});

    always_comb
    begin
        if (cmd.fetch_centre)
            rd_addr = {in_row, in_col};
        else if (cmd.step_window)
            rd_addr = {rr[ROW_W-1:0], cc[COL_W-1:0]};
        else
            rd_addr = {r_reg, c_reg};
    end

    always_ff @(posedge clk)
    begin
        if (cmd.write_en)
            mem[{in_row, in_col}] <= {in_missing, in_value};
        rd_reg <= mem[rd_addr];
    end

    assign wprod = $signed({1'b0, wt_reg}) * $signed(rd_reg[31:0]);
    assign mag   = acc_reg[ACC_W-1] ? ACC_W'(-acc_reg) : ACC_W'(acc_reg);
    assign lhs   = 48'({wvalid_reg, 16'h0});
    assign rhs   = 48'(min_valid_share) * 48'(wall_reg);

    msgs_divider u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.start_div),
        .dividend (mag + ACC_W'(wvalid_reg >> 1)),
        .divisor  (wvalid_reg),
        .done     (div_done),
        .quotient (quo)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.start_read)
        begin
            r_reg   <= in_row;
            c_reg   <= in_col;
            w_reg   <= (wcfg > 8'(MAX_WIDTH)) ? 9'(MAX_WIDTH) : {1'b0, wcfg};
            h_reg   <= (hcfg > 8'(MAX_HEIGHT)) ? 9'(MAX_HEIGHT) : {1'b0, hcfg};
            rad_reg <= (radius > 4'(MAX_RADIUS)) ? 4'(MAX_RADIUS) : radius;
            in_grid_reg <= ({1'b0, in_row} < hcfg) && ({1'b0, in_col} < wcfg) &&
                           (8'(in_row) < 8'(MAX_HEIGHT)) && (8'(in_col) < 8'(MAX_WIDTH));
            i_reg <= '0;
            j_reg <= '0;
            wall_reg   <= '0;
            wvalid_reg <= '0;
            acc_reg    <= '0;
        end
        else if (cmd.step_window)
        begin
            if (!last_issue_reg)
            begin
                if (i_reg == {rad_reg, 1'b0})
                begin
                    i_reg <= '0;
                    j_reg <= j_reg + 1'b1;
                end
                else
                begin
                    i_reg <= i_reg + 1'b1;
                end
            end
            if (p1v_reg)
            begin
                wall_reg <= wall_reg + WSUM_W'(wt_reg);
                if (p1in_reg && !rd_reg[32])
                begin
                    wvalid_reg <= wvalid_reg + WSUM_W'(wt_reg);
                    acc_reg    <= acc_reg + wprod;
                end
            end
        end
        if (cmd.step_window)
        begin
            wt_reg   <= 17'((prod + 34'd32768) >> 16);
            p1in_reg <= in_win;
        end
        if (cmd.load_out)
        begin
            if (stat.centre_bad)
            begin
                res_reg  <= '0;
                miss_reg <= 1'b1;
            end
            else if (stat.copy_mode)
            begin
                res_reg  <= rd_reg[31:0];
                miss_reg <= 1'b0;
            end
            else if (stat.share_bad)
            begin
                res_reg  <= '0;
                miss_reg <= 1'b1;
            end
            else
            begin
                miss_reg <= 1'b0;
                if (acc_reg[ACC_W-1])
                    res_reg <= (quo >= ACC_W'(32'h80000000)) ? 32'h80000000 : 32'(-quo);
                else
                    res_reg <= (quo >= ACC_W'(32'h80000000)) ? 32'h7FFFFFFF : quo[31:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1v_reg <= 1'b0;
            last_issue_reg <= 1'b0;
        end
        else if (cmd.start_read)
        begin
            p1v_reg <= 1'b0;
            last_issue_reg <= 1'b0;
        end
        else if (cmd.step_window)
        begin
            p1v_reg <= !last_issue_reg;
            if (last_issue)
                last_issue_reg <= 1'b1;
        end
    end

    assign stat.centre_bad  = !in_grid_reg || rd_reg[32];
    assign stat.copy_mode   = (rad_reg == '0);
    assign stat.window_done = last_issue_reg && !p1v_reg;
    assign stat.share_bad   = (lhs < rhs) || (wvalid_reg == '0);
    assign stat.div_done    = div_done;
    assign res_value   = res_reg;
    assign res_missing = miss_reg;

endmodule

// ===== hw/rtl/msgs_controller.sv =====
// Controller state machine sequencing writes, window walks and the divide.
module msgs_controller
    import msgs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        in_command,
    output logic        out_valid,
    input  logic        out_ready,
    output msgs_cmd_t   cmd,
    input  msgs_stat_t  stat
);

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_CENTRE = 7'b0000010,
        ST_CHECK  = 7'b0000100,
        ST_WALK   = 7'b0001000,
        ST_SHARE  = 7'b0010000,
        ST_DIV    = 7'b0100000,
        ST_OUT    = 7'b1000000
    } state_t;

    state_t state_reg, state_next;
    logic   ov_reg, ov_next;
    logic   take;
    logic   out_free;

    assign in_ready = (state_reg == ST_IDLE);
    assign take     = in_valid && in_ready;
    assign out_free = !ov_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        ov_next    = ov_reg && !out_ready;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.fetch_centre = 1'b1;
                if (take)
                begin
                    if (in_command == CMD_WRITE)
                        cmd.write_en = 1'b1;
                    else
                    begin
                        cmd.start_read = 1'b1;
                        state_next = ST_CENTRE;
                    end
                end
            end
            ST_CENTRE:
            begin
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                if (stat.centre_bad || stat.copy_mode)
                    state_next = ST_OUT;
                else
                    state_next = ST_WALK;
            end
            ST_WALK:
            begin
                cmd.step_window = 1'b1;
                if (stat.window_done)
                begin
                    cmd.step_window = 1'b0;
                    state_next = ST_SHARE;
                end
            end
            ST_SHARE:
            begin
                if (stat.share_bad)
                    state_next = ST_OUT;
                else
                begin
                    cmd.start_div = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (stat.div_done)
                    state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    cmd.load_out = 1'b1;
                    ov_next = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
        end
    end

    assign out_valid = ov_reg;

    a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
        take |-> state_reg == ST_IDLE)
        else $error("word taken while busy");
    a_out_after: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(ov_reg) |-> $past(state_reg) == ST_OUT)
        else $error("result raised outside output state");
    a_div_only: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.start_div |=> state_reg == ST_DIV)
        else $error("divide started without divide state");

endmodule

// ===== hw/rtl/masked_sinc_grid_smoother.sv =====
// Top level of the masked sinc grid smoother: streaming ports and register file.
// A write word is taken in the idle state, which the controller keeps. A read word goes from
// acceptance through the centre, check and output states when the centre is missing, out of
// the grid or the radius is 0; otherwise it also walks the (2r+1)^2 window through the one
// sample memory read port, checks the valid share and, if that share is met, runs the
// bit-serial divider. A result waits in an output register; writes are still taken
// meanwhile, and a following read holds in its output state until that register is free.
module masked_sinc_grid_smoother
    import msgs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // row[6:0], column[13:7], sample_value[45:14],
                                   // sample_missing[46], zero fill
    input  logic        s_tuser,   // command
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // filtered_value[31:0], filtered_missing[32], fill
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);

    logic [7:0]  width_reg, height_reg;
    logic [3:0]  radius_reg;
    logic [63:0] inner_reg, outer_reg;
    logic [15:0] share_reg;
    logic [2:0]  idx;
    msgs_cmd_t   cmd;
    msgs_stat_t  stat;
    logic [31:0] res_value;
    logic        res_missing;

    assign pready = 1'b1;
    assign idx = paddr[5:3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= 8'd128;
            height_reg <= 8'd128;
            radius_reg <= '0;
            inner_reg  <= '0;
            outer_reg  <= '0;
            share_reg  <= 16'd62259;
        end
        else if (psel && penable && pwrite && pready)
        begin
            case (idx)
                REG_WIDTH:  width_reg  <= pwdata[7:0];
                REG_HEIGHT: height_reg <= pwdata[7:0];
                REG_RADIUS: radius_reg <= pwdata[3:0];
                REG_INNER:  inner_reg  <= pwdata;
                REG_OUTER:  outer_reg  <= pwdata;
                REG_SHARE:  share_reg  <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_WIDTH:  prdata = 64'(width_reg);
            REG_HEIGHT: prdata = 64'(height_reg);
            REG_RADIUS: prdata = 64'(radius_reg);
            REG_INNER:  prdata = inner_reg;
            REG_OUTER:  prdata = outer_reg;
            REG_SHARE:  prdata = 64'(share_reg);
            default:    prdata = '0;
        endcase
    end

    msgs_controller u_ctrl
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_command (s_tuser),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .cmd        (cmd),
        .stat       (stat)
    );

    msgs_datapath u_dp
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .stat            (stat),
        .in_row          (s_tdata[6:0]),
        .in_col          (s_tdata[13:7]),
        .in_value        (s_tdata[45:14]),
        .in_missing      (s_tdata[46]),
        .grid_width      (width_reg),
        .grid_height     (height_reg),
        .radius          (radius_reg),
        .taps_inner      (inner_reg),
        .taps_outer      (outer_reg),
        .min_valid_share (share_reg),
        .res_value       (res_value),
        .res_missing     (res_missing)
    );

    assign m_tdata = {7'b0, res_missing, res_value};

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the masked sinc grid smoother: random streams, scoreboard, APB setup.
module tb;
    import msgs_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    class smooth_scoreboard;
        int unsigned cols;
        int unsigned rows;
        int unsigned rad;
        logic [63:0] taps_lo;
        logic [63:0] taps_hi;
        int unsigned share;
        logic [31:0] cell_value [DEPTH];
        bit cell_missing [DEPTH];
        logic [32:0] expected_words [$];
        int errors;
        int checked;

        function new();
            cols = 128;
            rows = 128;
            rad = 0;
            taps_lo = '0;
            taps_hi = '0;
            share = 62259;
            errors = 0;
            checked = 0;
        endfunction

        function void set_reg(logic [2:0] idx, logic [63:0] d);
            case (idx)
                REG_WIDTH:  cols = d[7:0];
                REG_HEIGHT: rows = d[7:0];
                REG_RADIUS: rad = d[3:0];
                REG_INNER:  taps_lo = d;
                REG_OUTER:  taps_hi = d;
                REG_SHARE:  share = d[15:0];
                default: ;
            endcase
        endfunction

        function longint unsigned sinc_tap(int k);
            longint unsigned t;
            t = 0;
            if (k == 0)
                t = 65536;
            else if (k <= 4)
                t = (taps_lo >> (16 * (k - 1))) & 64'hFFFF;
            else if (k <= 8)
                t = (taps_hi >> (16 * (k - 5))) & 64'hFFFF;
            return t;
        endfunction

        function logic [32:0] smoothed(int r, int c);
            int w;
            int h;
            int rd;
            int rr;
            int cc;
            int idx;
            longint unsigned wall;
            longint unsigned wvalid;
            longint unsigned wt;
            longint unsigned mag;
            longint unsigned q;
            longint acc;
            longint res;
            w = (cols > 128) ? 128 : cols;
            h = (rows > 128) ? 128 : rows;
            rd = (rad > 8) ? 8 : rad;
            wall = 0;
            wvalid = 0;
            acc = 0;
            if (r >= h || c >= w)
                return {1'b1, 32'd0};
            idx = r * MAX_WIDTH + c;
            if (cell_missing[idx])
                return {1'b1, 32'd0};
            if (rd == 0)
                return {1'b0, cell_value[idx]};
            for (int j = -rd; j <= rd; j++) begin
                for (int i = -rd; i <= rd; i++) begin
                    wt = (sinc_tap(i < 0 ? -i : i) * sinc_tap(j < 0 ? -j : j) + 32768) >> 16;
                    rr = r + j;
                    cc = c + i;
                    wall += wt;
                    if (rr >= 0 && rr < h && cc >= 0 && cc < w) begin
                        idx = rr * MAX_WIDTH + cc;
                        if (!cell_missing[idx]) begin
                            wvalid += wt;
                            acc += longint'($signed(cell_value[idx])) * longint'(wt);
                        end
                    end
                end
            end
            if (wvalid * 65536 < longint'(share) * wall || wvalid == 0)
                return {1'b1, 32'd0};
            mag = (acc < 0) ? longint'(-acc) : longint'(acc);
            q = (mag + wvalid / 2) / wvalid;
            if (q > 64'h80000000)
                q = 64'h80000000;
            res = (acc < 0) ? -longint'(q) : longint'(q);
            if (res > 2147483647)
                res = 2147483647;
            return {1'b0, res[31:0]};
        endfunction

        function void note_word(logic cmd, int r, int c, logic [31:0] v, bit m);
            if (cmd == CMD_WRITE) begin
                cell_value[r * MAX_WIDTH + c] = v;
                cell_missing[r * MAX_WIDTH + c] = m;
            end else begin
                expected_words.push_back(smoothed(r, c));
            end
        endfunction

        task report(string what);
            $display("MISMATCH at %0t: %s", $realtime, what);
            errors++;
        endtask

        task check_word(logic [32:0] got);
            logic [32:0] want;
            checked++;
            if (expected_words.size() == 0) begin
                report($sformatf("result word %h with nothing expected", got));
            end else begin
                want = expected_words.pop_front();
                if (got[32] !== want[32])
                    report($sformatf("missing flag %b, expected %b", got[32], want[32]));
                if (got[31:0] !== want[31:0])
                    report($sformatf("value %h, expected %h", got[31:0], want[31:0]));
            end
        endtask
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [5:0]  paddr;
    logic [63:0] pwdata;
    logic [63:0] prdata;
    logic        pready;

    smooth_scoreboard sb;
    bit written [DEPTH];
    bit fast_tx;
    bit fast_rx;
    int hold_cycles;
    int reads_sent;
    int writes_sent;
    int phases_run;
    longint cycles;

    masked_sinc_grid_smoother u_dut (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > 4000000)
            begin
                $display("timeout after %0d cycles", cycles);
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && s_tready)
            sb.note_word(s_tuser, s_tdata[6:0], s_tdata[13:7], s_tdata[45:14], s_tdata[46]);
        if (rst_n && m_tvalid && m_tready)
            sb.check_word(m_tdata[32:0]);
    end

    initial
    begin
        int stall;
        @(posedge rst_n);
        forever
        begin
            if (hold_cycles > 0)
            begin
                m_tready <= 1'b0;
                repeat (hold_cycles) @(posedge clk);
                hold_cycles = 0;
            end
            stall = fast_rx ? 0 : $urandom_range(0, 18);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid) @(posedge clk);
        end
    end

    task automatic apb_write(logic [2:0] idx, logic [63:0] d);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 3'b000};
        pwdata <= d;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        sb.set_reg(idx, d);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.expected_words.size() != 0) @(posedge clk);
    endtask

    task automatic configure(int w, int h, int rad, logic [63:0] ti, logic [63:0] to, int share);
        drain();
        repeat (8) @(posedge clk);
        apb_write(REG_WIDTH, 64'(w));
        apb_write(REG_HEIGHT, 64'(h));
        apb_write(REG_RADIUS, 64'(rad));
        apb_write(REG_INNER, ti);
        apb_write(REG_OUTER, to);
        apb_write(REG_SHARE, 64'(share));
        phases_run++;
    endtask

    task automatic send_word(logic cmd, int r, int c, logic [31:0] v, bit m);
        int gap;
        gap = fast_tx ? 0 : $urandom_range(0, 18);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= cmd;
        s_tdata <= {1'b0, m, v, c[6:0], r[6:0]};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        if (cmd == CMD_WRITE)
        begin
            written[r * MAX_WIDTH + c] = 1'b1;
            writes_sent++;
        end else begin
            reads_sent++;
        end
    endtask

    function automatic logic [31:0] rand_sample();
        case ($urandom_range(0, 5))
            0: return 32'h7FFFFFFF - $urandom_range(0, 3);
            1: return 32'h80000000 + $urandom_range(0, 3);
            2: return $urandom_range(0, 4095) - 2048;
            default: return $urandom;
        endcase
    endfunction

    function automatic bit rand_missing();
        return $urandom_range(0, 99) < 12;
    endfunction

    task automatic read_cell(int r, int c);
        int w;
        int h;
        int rd;
        w = (sb.cols > 128) ? 128 : sb.cols;
        h = (sb.rows > 128) ? 128 : sb.rows;
        rd = (sb.rad > 8) ? 8 : sb.rad;
        if (r < h && c < w)
        begin
            for (int rr = r - rd; rr <= r + rd; rr++)
                for (int cc = c - rd; cc <= c + rd; cc++)
                    if (rr >= 0 && rr < h && cc >= 0 && cc < w && !written[rr * MAX_WIDTH + cc])
                        send_word(CMD_WRITE, rr, cc, rand_sample(), rand_missing());
        end
        send_word(CMD_READ, r, c, '0, 1'b0);
    endtask

    task automatic random_phase(int n_items);
        int w;
        int h;
        int wr;
        int hr;
        int r;
        int c;
        w = (sb.cols > 128) ? 128 : sb.cols;
        h = (sb.rows > 128) ? 128 : sb.rows;
        wr = (w > 16) ? 16 : w;
        hr = (h > 16) ? 16 : h;
        for (int k = 0; k < n_items; k++)
        begin
            if (w == 0 || h == 0 || $urandom_range(0, 9) == 0)
            begin
                r = $urandom_range(0, 127);
                c = $urandom_range(0, 127);
                if (r < h && c < w)
                    send_word(CMD_WRITE, r, c, rand_sample(), rand_missing());
                else
                    send_word(CMD_READ, r, c, '0, 1'b0);
            end else begin
                r = $urandom_range(0, hr - 1);
                c = $urandom_range(0, wr - 1);
                if ($urandom_range(0, 9) < 6)
                    read_cell(r, c);
                else
                    send_word(CMD_WRITE, r, c, rand_sample(), rand_missing());
            end
        end
    endtask

    function automatic logic [63:0] rand_taps();
        return {16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535))};
    endfunction

    initial
    begin
        int w;
        int h;
        int rad;
        int share;
        sb = new();
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = CMD_WRITE;
        m_tready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        fast_tx = 1'b0;
        fast_rx = 1'b0;
        hold_cycles = 0;
        reads_sent = 0;
        writes_sent = 0;
        phases_run = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_word(CMD_WRITE, 0, 0, 32'h7FFFFFFF, 1'b0);
        send_word(CMD_WRITE, 127, 127, 32'h80000000, 1'b0);
        send_word(CMD_WRITE, 5, 5, 32'h0, 1'b1);
        send_word(CMD_WRITE, 1, 1, 32'hFFFFFFFF, 1'b0);
        read_cell(0, 0);
        read_cell(127, 127);
        read_cell(5, 5);
        read_cell(1, 1);
        configure(10, 10, 0, 64'h0, 64'h0, 62259);
        read_cell(20, 3);
        read_cell(3, 20);
        send_word(CMD_WRITE, 50, 50, 32'h00001234, 1'b0);
        configure(0, 0, 0, 64'h0, 64'h0, 62259);
        read_cell(0, 0);
        configure(255, 255, 15, 64'hFFFFFFFFFFFFFFFF, 64'hFFFFFFFFFFFFFFFF, 0);
        read_cell(50, 50);
        read_cell(0, 0);
        configure(8, 8, 1, 64'h4000_8000_C000_F000, 64'h0, 65535);
        read_cell(3, 3);
        read_cell(0, 7);

        for (int p = 0; p < 10; p++)
        begin
            case ($urandom_range(0, 4))
                0: w = $urandom_range(1, 4);
                1: w = (p == 4) ? 128 : 255;
                2: w = (p == 7) ? 0 : 12;
                default: w = $urandom_range(1, 24);
            endcase
            h = (p % 3 == 0) ? $urandom_range(1, 24) : w;
            rad = (p == 6) ? 8 : (p == 8) ? $urandom_range(9, 15) : $urandom_range(0, 3);
            share = (p == 1) ? 0 : (p == 2) ? 65535 : $urandom_range(0, 65535);
            configure(w, h, rad, rand_taps(), rand_taps(), share);
            fast_tx = (p == 3);
            fast_rx = (p == 3) || (p == 9);
            if (p == 2)
                hold_cycles = 3000;
            random_phase(((p == 6) || (p == 8)) ? 60 : 130);
            if (p == 5)
            begin
                drain();
                random_phase(40);
            end
        end
        drain();
        repeat (400) @(posedge clk);

        $display("covered %0d phases: %0d writes, %0d reads, %0d results checked",
                 phases_run, writes_sent, reads_sent, sb.checked);
        if (sb.errors == 0 && sb.expected_words.size() == 0)
        begin
            $display("end of test: clean");
        end else begin
            $display("%0d errors, %0d results never arrived", sb.errors,
                     sb.expected_words.size());
            $display("end of test: mismatches");
        end
        $finish;
    end
endmodule
